// ===== sv/load_cell_adc_serial_reader_unit_defines.svh =====
// Assertion macros shared by the load cell readout RTL.
`ifndef LOAD_CELL_ADC_SERIAL_READER_UNIT_DEFINES_SVH
`define LOAD_CELL_ADC_SERIAL_READER_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define LCAR_ASSERT_IMPLIES(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lcar: same-cycle check failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define LCAR_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lcar: next-cycle check failed");

`endif

// ===== sv/lcar_pkg.sv =====
`default_nettype none
package lcar_pkg;

   localparam int DATA_BITS_DEF = 24;

   localparam int HALF_W   = 16;
   localparam int GAIN_W   = 24;
   localparam int BIAS_W   = 16;
   localparam int RAW_W    = 24;
   localparam int WEIGHT_W = 31;
   localparam int FRAC_W   = 16;
   localparam int WIDE_W   = 64;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_HALF_PERIOD = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_RECIP_GAIN  = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_BIAS        = CSR_IDX_W'(2);

   localparam logic [HALF_W-1:0] HALF_PERIOD_RST = HALF_W'(1);
   localparam logic [GAIN_W-1:0] RECIP_GAIN_RST  = GAIN_W'(145636);
   localparam logic [BIAS_W-1:0] BIAS_RST        = BIAS_W'(2510);

   localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = {WEIGHT_W{1'b1}};

   // Request beat: dout, start_req, op from bit 0 up, padded to one byte.
   localparam int REQ_W       = 8;
   localparam int REQ_DOUT    = 0;
   localparam int REQ_START   = 1;
   localparam int REQ_OP      = 2;

   // Response beat: sck, busy_res, done_res, raw, weight from bit 0 up.
   localparam int RSP_PAY_W = 3 + RAW_W + WEIGHT_W;
   localparam int RSP_W     = 64;

   typedef logic [RAW_W-1:0]    raw_type;
   typedef logic [WEIGHT_W-1:0] weight_type;

   typedef struct packed {
      logic fire;
      logic tare_op;
   } finish_type;

endpackage
`default_nettype wire

// ===== sv/lcar_seq.sv =====
`default_nettype none
module lcar_seq #(
   parameter int DATA_BITS = lcar_pkg::DATA_BITS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           step,
   input  wire logic                           dout,
   input  wire logic                           start_req,
   input  wire logic                           op,
   input  wire logic [lcar_pkg::HALF_W-1:0]    half_period,
   output logic                                sck_next,
   output logic                                busy_next,
   output lcar_pkg::finish_type                fin,
   output logic [DATA_BITS-1:0]                reading
);

   localparam int CntW = $clog2(DATA_BITS + 1);
   localparam logic [CntW-1:0] LastBit = CntW'(DATA_BITS - 1);
   localparam logic [DATA_BITS-1:0] TopBit = {1'b1, {(DATA_BITS-1){1'b0}}};

   typedef enum logic [2:0] {
      PH_IDLE, PH_WAIT, PH_HIGH, PH_LOW, PH_XHIGH, PH_XLOW
   } phase_type;

   phase_type                   phase_ff, phase_in;
   logic [CntW-1:0]             bits_ff, bits_in;
   logic [lcar_pkg::HALF_W-1:0] timer_ff, timer_in;
   logic [DATA_BITS-1:0]        shift_ff, shift_in;
   logic                        op_ff, op_in;

   logic [lcar_pkg::HALF_W-1:0] hp;
   logic [lcar_pkg::HALF_W-1:0] tick_inc;
   logic [lcar_pkg::HALF_W-1:0] timer_adv;
   logic                        half_end;

   // A zero half period behaves as one tick; the timer wraps at 16 bits.
   assign hp        = (half_period == '0) ? lcar_pkg::HALF_W'(1) : half_period;
   assign tick_inc  = timer_ff + lcar_pkg::HALF_W'(1);
   assign half_end  = (tick_inc >= hp) || (tick_inc == '0);
   assign timer_adv = half_end ? '0 : tick_inc;

   always_comb begin
      phase_in    = phase_ff;
      bits_in     = bits_ff;
      timer_in    = timer_ff;
      shift_in    = shift_ff;
      op_in       = op_ff;
      fin.fire    = 1'b0;
      fin.tare_op = op_ff;
      unique case (phase_ff)
         PH_IDLE: begin
            if (start_req) begin
               op_in    = op;
               bits_in  = '0;
               timer_in = '0;
               shift_in = '0;
               phase_in = PH_WAIT;
            end
         end
         PH_WAIT: begin
            if (!dout) begin
               timer_in = '0;
               phase_in = PH_HIGH;
            end
         end
         PH_HIGH: begin
            timer_in = timer_adv;
            if (half_end) phase_in = PH_LOW;
         end
         PH_LOW: begin
            timer_in = timer_adv;
            if (half_end) begin
               shift_in = {shift_ff[DATA_BITS-2:0], dout};
               bits_in  = bits_ff + CntW'(1);
               phase_in = (bits_ff == LastBit) ? PH_XHIGH : PH_HIGH;
            end
         end
         PH_XHIGH: begin
            timer_in = timer_adv;
            if (half_end) phase_in = PH_XLOW;
         end
         PH_XLOW: begin
            timer_in = timer_adv;
            if (half_end) begin
               fin.fire = 1'b1;
               phase_in = PH_IDLE;
            end
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   assign sck_next  = (phase_in == PH_HIGH) || (phase_in == PH_XHIGH);
   assign busy_next = (phase_in != PH_IDLE);

   // The shift register holds still through the extra pulse, so the reading
   // is settled well before the readout finishes.
   assign reading = shift_ff ^ TopBit;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         bits_ff  <= '0;
         timer_ff <= '0;
         shift_ff <= '0;
         op_ff    <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         bits_ff  <= bits_in;
         timer_ff <= timer_in;
         shift_ff <= shift_in;
         op_ff    <= op_in;
      end
   end

endmodule
`default_nettype wire

// ===== sv/lcar_scale.sv =====
`default_nettype none
module lcar_scale #(
   parameter int DATA_BITS = lcar_pkg::DATA_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          step,
   input  wire lcar_pkg::finish_type          fin,
   input  wire logic [DATA_BITS-1:0]          reading,
   input  wire logic [lcar_pkg::GAIN_W-1:0]   recip_gain,
   input  wire logic [lcar_pkg::BIAS_W-1:0]   bias,
   output lcar_pkg::raw_type                  raw_next,
   output lcar_pkg::weight_type               weight_next
);

   localparam int ProdW = DATA_BITS + lcar_pkg::GAIN_W;

   logic [DATA_BITS-1:0]       tare_ff, tare_in;
   lcar_pkg::raw_type          raw_ff;
   lcar_pkg::weight_type       weight_ff;
   logic [ProdW-1:0]           prod_ff, prod_in;
   logic                       above_ff, above_in;

   logic [DATA_BITS-1:0]       net;
   logic [ProdW-1:0]           bias_ext;
   logic [ProdW-1:0]           diff;
   logic [lcar_pkg::WIDE_W-1:0] shifted;
   lcar_pkg::weight_type       scaled;
   logic                       weigh_fire;

   // The product is formed every cycle from the settled reading; tare cannot
   // move while a readout is running. The gain arrives as it will stand after
   // this edge, so a write just before the readout ends is still seen.
   assign net      = reading - tare_ff;
   assign prod_in  = ProdW'(net) * ProdW'(recip_gain);
   assign above_in = reading > tare_ff;

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      above_ff <= above_in;
   end

   assign bias_ext = ProdW'(bias);
   assign diff     = prod_ff - bias_ext;
   assign shifted  = lcar_pkg::WIDE_W'(diff >> lcar_pkg::FRAC_W);

   always_comb begin
      if (prod_ff < bias_ext) begin
         scaled = '0;
      end else if (shifted > lcar_pkg::WIDE_W'(lcar_pkg::WEIGHT_MAX)) begin
         scaled = lcar_pkg::WEIGHT_MAX;
      end else begin
         scaled = lcar_pkg::weight_type'(shifted);
      end
   end

   assign weigh_fire  = fin.fire && !fin.tare_op;
   assign raw_next    = weigh_fire ? lcar_pkg::raw_type'(reading) : raw_ff;
   assign weight_next = (weigh_fire && above_ff) ? scaled : weight_ff;
   assign tare_in     = (fin.fire && fin.tare_op) ? reading : tare_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tare_ff   <= '0;
         raw_ff    <= '0;
         weight_ff <= '0;
      end else if (step) begin
         tare_ff   <= tare_in;
         raw_ff    <= raw_next;
         weight_ff <= weight_next;
      end
   end

endmodule
`default_nettype wire

// ===== sv/load_cell_adc_serial_reader_unit.sv =====
// The response beat for a request beat is registered, valid in the cycle after it is accepted.
// One request beat per cycle, unless the response stalls; each beat is one converter link tick.
// A readout spans the start beat, one or more wait beats, and then
// 2 * half_period * (DATA_BITS + 1) beats, a zero half period counting as one.
// Reset (synchronous, active high) idles the sequencer, clears tare, raw and weight,
// empties the response register and restores the configuration defaults.
`default_nettype none
`include "load_cell_adc_serial_reader_unit_defines.svh"
module load_cell_adc_serial_reader_unit #(
   parameter int DATA_BITS = lcar_pkg::DATA_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // Fields from bit 0: dout, start_req, op, then zero padding.
   input  wire logic [lcar_pkg::REQ_W-1:0]        req_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // Fields from bit 0: sck, busy_res, done_res, raw[23:0], weight[30:0], then zeros.
   output logic [lcar_pkg::RSP_W-1:0]             rsp_tdata,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [lcar_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [lcar_pkg::CSR_DATA_W-1:0]   csr_data
);

   logic [lcar_pkg::HALF_W-1:0]  half_period_ff;
   logic [lcar_pkg::GAIN_W-1:0]  recip_gain_ff, recip_gain_in;
   logic [lcar_pkg::BIAS_W-1:0]  bias_ff;

   logic                         rsp_tvalid_ff;
   logic [lcar_pkg::RSP_W-1:0]   rsp_tdata_ff, rsp_tdata_in;

   logic                         step;
   logic                         sck_next;
   logic                         busy_next;
   lcar_pkg::finish_type         fin;
   logic [DATA_BITS-1:0]         reading;
   lcar_pkg::raw_type            raw_next;
   lcar_pkg::weight_type         weight_next;

   assign csr_ready = 1'b1;

   // The scaler's product register is fed the gain as it stands after this edge.
   assign recip_gain_in = (csr_valid && csr_ready && (csr_index == lcar_pkg::CSR_RECIP_GAIN))
                          ? csr_data[lcar_pkg::GAIN_W-1:0] : recip_gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff <= lcar_pkg::HALF_PERIOD_RST;
         recip_gain_ff  <= lcar_pkg::RECIP_GAIN_RST;
         bias_ff        <= lcar_pkg::BIAS_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            lcar_pkg::CSR_HALF_PERIOD: half_period_ff <= csr_data[lcar_pkg::HALF_W-1:0];
            lcar_pkg::CSR_RECIP_GAIN:  recip_gain_ff  <= recip_gain_in;
            lcar_pkg::CSR_BIAS:        bias_ff        <= csr_data[lcar_pkg::BIAS_W-1:0];
            default: ;
         endcase
      end
   end

   // The response register parts the two sides: a new beat enters when none is held
   // or when the held one leaves in the same cycle.
   assign req_tready = !rsp_tvalid_ff || rsp_tready;
   assign step       = req_tvalid && req_tready;

   lcar_seq #(
      .DATA_BITS (DATA_BITS)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .dout        (req_tdata[lcar_pkg::REQ_DOUT]),
      .start_req   (req_tdata[lcar_pkg::REQ_START]),
      .op          (req_tdata[lcar_pkg::REQ_OP]),
      .half_period (half_period_ff),
      .sck_next    (sck_next),
      .busy_next   (busy_next),
      .fin         (fin),
      .reading     (reading)
   );

   lcar_scale #(
      .DATA_BITS (DATA_BITS)
   ) u_scale (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .fin         (fin),
      .reading     (reading),
      .recip_gain  (recip_gain_in),
      .bias        (bias_ff),
      .raw_next    (raw_next),
      .weight_next (weight_next)
   );

   assign rsp_tdata_in = lcar_pkg::RSP_W'({weight_next, raw_next, fin.fire, busy_next,
                                           sck_next});

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (step) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // A finishing beat always returns the link to idle with the clock low.
   `LCAR_ASSERT_IMPLIES(a_done_idle, clock, reset, rsp_tvalid && rsp_tdata[2],
                        !rsp_tdata[1] && !rsp_tdata[0])
   // The serial clock is only driven during a readout.
   `LCAR_ASSERT_IMPLIES(a_sck_busy, clock, reset, rsp_tvalid && rsp_tdata[0], rsp_tdata[1])
   // An accepted request beat always leaves a response beat waiting.
   `LCAR_ASSERT_NEXT(a_step_rsp, clock, reset, step, rsp_tvalid)
   // A stalled response beat blocks the request side.
   `LCAR_ASSERT_IMPLIES(a_stall_block, clock, reset, rsp_tvalid && !rsp_tready, !req_tready)

endmodule
`default_nettype wire
